// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// ===== hdl/usgc_pkg.sv =====
package usgc_pkg;

    localparam logic KIND_DISTINCT = 1'b0;
    localparam logic KIND_INVERSE  = 1'b1;

    typedef struct packed {
        logic key_we;
        logic key_ra_gf;
        logic latch_j;
        logic acc_a;
        logic acc_b;
        logic wr_a;
        logic wr_b;
        logic out_load;
        logic out_kind;
        logic out_last;
    } usgc_cmd_t;

endpackage

// ===== hdl/unique_sort_group_count.sv =====
// Groups a set of signed keys loaded one word per cycle (up to CAPACITY, extras
// dropped and flagged) until a word marked last. It then emits one distinct-key
// word per group (key, first index, count) in ascending-key or first-seen order
// per the sorted_reg register, followed by one group-index word per loaded
// key, the final word flagged last. After the last key, with n keys and g
// groups, grouping runs a first-occurrence pass and then a ranking pass,
// all through one read port on the key store; emission produces g + n
// words and waits whenever the sink is not ready. New keys are taken once
// the final word has been registered.
module unique_sort_group_count #(
    parameter int CAPACITY  = 32,
    parameter int KEY_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_key_value,
    input  logic        s_last_item,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [31:0] m_distinct_key,
    output logic [4:0]  m_first_position,
    output logic [5:0]  m_occurrences,
    output logic [4:0]  m_group_index,
    output logic        m_overflow,
    output logic        m_last_result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    `include "assert_macros.svh"

    localparam int IW = $clog2(CAPACITY);

    usgc_pkg::usgc_cmd_t cmd;
    logic [IW-1:0] addr, jidx;
    logic          ovf, j_first;

    assign cfg_ready = 1'b1;

    usgc_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_last_item (s_last_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .j_first     (j_first),
        .cmd         (cmd),
        .addr        (addr),
        .jidx        (jidx),
        .ovf         (ovf)
    );

    usgc_datapath #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH)) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .addr             (addr),
        .jidx             (jidx),
        .key_in           (s_key_value),
        .ovf_in           (ovf),
        .cfg_we           (cfg_valid),
        .cfg_data         (cfg_data),
        .j_first          (j_first),
        .o_kind           (m_kind),
        .o_distinct_key   (m_distinct_key),
        .o_first_position (m_first_position),
        .o_occurrences    (m_occurrences),
        .o_group_index    (m_group_index),
        .o_overflow       (m_overflow),
        .o_last_result    (m_last_result)
    );

    `ASSERT_NEXT(a_last_stops_load, s_valid && s_ready && s_last_item, !s_ready)
    `ASSERT_IMPL(a_load_only_after_last, s_ready && m_valid, m_last_result)
    `ASSERT_IMPL(a_inverse_clean, m_valid && m_kind, m_occurrences == '0 && m_distinct_key == '0)

endmodule

// ===== hdl/usgc_datapath.sv =====
module usgc_datapath #(
    parameter int CAPACITY  = 32,
    parameter int KEY_WIDTH = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  usgc_pkg::usgc_cmd_t       cmd,
    input  logic [$clog2(CAPACITY)-1:0] addr,
    input  logic [$clog2(CAPACITY)-1:0] jidx,
    input  logic [31:0]               key_in,
    input  logic                      ovf_in,
    input  logic                      cfg_we,
    input  logic                      cfg_data,
    output logic                      j_first,
    output logic                      o_kind,
    output logic [31:0]               o_distinct_key,
    output logic [4:0]                o_first_position,
    output logic [5:0]                o_occurrences,
    output logic [4:0]                o_group_index,
    output logic                      o_overflow,
    output logic                      o_last_result
);
    localparam int IW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int SKW = (KEY_WIDTH > 32) ? 33 : KEY_WIDTH;

    logic [SKW-1:0] key_mem    [CAPACITY];
    logic [IW-1:0]  rep_mem    [CAPACITY];
    logic [IW-1:0]  pos_mem    [CAPACITY];
    logic [IW-1:0]  gfirst_mem [CAPACITY];
    logic [CW-1:0]  gcount_mem [CAPACITY];

    logic [SKW-1:0] key_ext;
    logic [SKW-1:0] key_rd_reg;
    logic [SKW-1:0] keyj_reg;
    logic [IW-1:0]  rep_rd_reg;
    logic [IW-1:0]  pos_rd_reg;
    logic [IW-1:0]  gfirst_rd_reg;
    logic [CW-1:0]  gcount_rd_reg;
    logic [IW-1:0]  key_ra;
    logic [31:0]    key_out;

    logic           sorted_reg;
    logic           acc_a_reg, acc_b_reg;
    logic [IW-1:0]  kd_reg;
    logic           found_reg;
    logic [IW-1:0]  rep_acc_reg;
    logic [IW-1:0]  pos_acc_reg;
    logic [CW-1:0]  cnt_acc_reg;
    logic           eq, less;

    generate
        if (KEY_WIDTH > 32) begin : g_wide
            assign key_ext = {1'b0, key_in};
            assign key_out = key_rd_reg[31:0];
        end else if (KEY_WIDTH == 32) begin : g_full
            assign key_ext = key_in;
            assign key_out = key_rd_reg;
        end else begin : g_narrow
            assign key_ext = key_in[SKW-1:0];
            assign key_out = {{(32-SKW){key_rd_reg[SKW-1]}}, key_rd_reg};
        end
    endgenerate

    assign key_ra  = cmd.key_ra_gf ? gfirst_rd_reg : addr;
    assign eq      = (key_rd_reg == keyj_reg);
    assign less    = sorted_reg ? ($signed(key_rd_reg) < $signed(keyj_reg)) : (kd_reg < jidx);
    assign j_first = (rep_rd_reg == jidx);

    always_ff @(posedge aclk) begin
        if (cmd.key_we) begin
            key_mem[addr] <= key_ext;
        end
        key_rd_reg <= key_mem[key_ra];
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_a) begin
            rep_mem[jidx] <= rep_acc_reg;
        end
        rep_rd_reg <= rep_mem[addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_b) begin
            pos_mem[jidx] <= pos_acc_reg;
        end
        pos_rd_reg <= pos_mem[rep_rd_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_b) begin
            gfirst_mem[pos_acc_reg] <= jidx;
            gcount_mem[pos_acc_reg] <= cnt_acc_reg;
        end
        gfirst_rd_reg <= gfirst_mem[addr];
        gcount_rd_reg <= gcount_mem[addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sorted_reg <= 1'b1;
            acc_a_reg  <= 1'b0;
            acc_b_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                sorted_reg <= cfg_data;
            end
            acc_a_reg <= cmd.acc_a;
            acc_b_reg <= cmd.acc_b;
        end
    end

    always_ff @(posedge aclk) begin
        kd_reg <= addr;
        if (cmd.latch_j) begin
            keyj_reg    <= key_rd_reg;
            found_reg   <= 1'b0;
            rep_acc_reg <= '0;
            pos_acc_reg <= '0;
            cnt_acc_reg <= '0;
        end else begin
            if (acc_a_reg && eq && !found_reg) begin
                found_reg   <= 1'b1;
                rep_acc_reg <= kd_reg;
            end
            if (acc_b_reg) begin
                if (eq) begin
                    cnt_acc_reg <= cnt_acc_reg + CW'(1);
                end
                if (kd_reg != jidx && rep_rd_reg == kd_reg && less) begin
                    pos_acc_reg <= pos_acc_reg + IW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            o_kind        <= cmd.out_kind;
            o_overflow    <= ovf_in;
            o_last_result <= cmd.out_last;
            if (cmd.out_kind == usgc_pkg::KIND_DISTINCT) begin
                o_distinct_key   <= key_out;
                o_first_position <= 5'(gfirst_rd_reg);
                o_occurrences    <= 6'(gcount_rd_reg);
                o_group_index    <= '0;
            end else begin
                o_distinct_key   <= '0;
                o_first_position <= '0;
                o_occurrences    <= '0;
                o_group_index    <= 5'(pos_rd_reg);
            end
        end
    end

endmodule

// ===== hdl/usgc_ctrl.sv =====
module usgc_ctrl #(
    parameter int CAPACITY = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_last_item,
    output logic                        m_valid,
    input  logic                        m_ready,
    input  logic                        j_first,
    output usgc_pkg::usgc_cmd_t         cmd,
    output logic [$clog2(CAPACITY)-1:0] addr,
    output logic [$clog2(CAPACITY)-1:0] jidx,
    output logic                        ovf
);
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [4:0] S_LOAD   = 5'd0;
    localparam logic [4:0] S_A_J    = 5'd1;
    localparam logic [4:0] S_A_JL   = 5'd2;
    localparam logic [4:0] S_A_RUN  = 5'd3;
    localparam logic [4:0] S_A_DR   = 5'd4;
    localparam logic [4:0] S_A_WR   = 5'd5;
    localparam logic [4:0] S_B_J    = 5'd6;
    localparam logic [4:0] S_B_JL   = 5'd7;
    localparam logic [4:0] S_B_RUN  = 5'd8;
    localparam logic [4:0] S_B_DR   = 5'd9;
    localparam logic [4:0] S_B_WR   = 5'd10;
    localparam logic [4:0] S_E0_R1  = 5'd11;
    localparam logic [4:0] S_E0_R2  = 5'd12;
    localparam logic [4:0] S_E0_OUT = 5'd13;
    localparam logic [4:0] S_E1_R1  = 5'd14;
    localparam logic [4:0] S_E1_R2  = 5'd15;
    localparam logic [4:0] S_E1_OUT = 5'd16;

    logic [4:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] groups_reg, groups_next;
    logic [IW-1:0] j_reg, j_next;
    logic [IW-1:0] k_reg, k_next;
    logic          ovf_reg, ovf_next;
    logic          m_valid_reg, m_valid_next;
    logic          out_free, j_last, k_last_n, g_last;

    assign out_free = !m_valid_reg || m_ready;
    assign j_last   = (CW'(j_reg) == cnt_reg - CW'(1));
    assign k_last_n = (CW'(k_reg) == cnt_reg - CW'(1));
    assign g_last   = (CW'(j_reg) == groups_reg - CW'(1));
    assign s_ready  = (state_reg == S_LOAD);
    assign m_valid  = m_valid_reg;
    assign jidx     = j_reg;
    assign ovf      = ovf_reg;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        groups_next  = groups_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_ready ? 1'b0 : m_valid_reg;
        cmd          = '0;
        addr         = j_reg;
        case (state_reg)
            S_LOAD: begin
                addr = cnt_reg[IW-1:0];
                if (s_valid) begin
                    if (cnt_reg < CW'(CAPACITY)) begin
                        cmd.key_we = 1'b1;
                        cnt_next   = cnt_reg + CW'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_last_item) begin
                        j_next     = '0;
                        state_next = S_A_J;
                    end
                end
            end
            S_A_J: state_next = S_A_JL;
            S_A_JL: begin
                cmd.latch_j = 1'b1;
                k_next      = '0;
                state_next  = S_A_RUN;
            end
            S_A_RUN: begin
                addr      = k_reg;
                cmd.acc_a = 1'b1;
                k_next    = k_reg + IW'(1);
                if (k_reg == j_reg) begin
                    state_next = S_A_DR;
                end
            end
            S_A_DR: state_next = S_A_WR;
            S_A_WR: begin
                cmd.wr_a = 1'b1;
                if (j_last) begin
                    j_next     = '0;
                    state_next = S_B_J;
                end else begin
                    j_next     = j_reg + IW'(1);
                    state_next = S_A_J;
                end
            end
            S_B_J: state_next = S_B_JL;
            S_B_JL: begin
                cmd.latch_j = 1'b1;
                k_next      = '0;
                if (j_first) begin
                    state_next = S_B_RUN;
                end else if (j_last) begin
                    j_next     = '0;
                    state_next = S_E0_R1;
                end else begin
                    j_next     = j_reg + IW'(1);
                    state_next = S_B_J;
                end
            end
            S_B_RUN: begin
                addr      = k_reg;
                cmd.acc_b = 1'b1;
                k_next    = k_reg + IW'(1);
                if (k_last_n) begin
                    state_next = S_B_DR;
                end
            end
            S_B_DR: state_next = S_B_WR;
            S_B_WR: begin
                cmd.wr_b    = 1'b1;
                groups_next = groups_reg + CW'(1);
                if (j_last) begin
                    j_next     = '0;
                    state_next = S_E0_R1;
                end else begin
                    j_next     = j_reg + IW'(1);
                    state_next = S_B_J;
                end
            end
            S_E0_R1: state_next = S_E0_R2;
            S_E0_R2: begin
                cmd.key_ra_gf = 1'b1;
                state_next    = S_E0_OUT;
            end
            S_E0_OUT: begin
                cmd.key_ra_gf = 1'b1;
                cmd.out_kind  = usgc_pkg::KIND_DISTINCT;
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    if (g_last) begin
                        j_next     = '0;
                        state_next = S_E1_R1;
                    end else begin
                        j_next     = j_reg + IW'(1);
                        state_next = S_E0_R1;
                    end
                end
            end
            S_E1_R1: state_next = S_E1_R2;
            S_E1_R2: state_next = S_E1_OUT;
            S_E1_OUT: begin
                cmd.out_kind = usgc_pkg::KIND_INVERSE;
                cmd.out_last = j_last;
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    if (j_last) begin
                        cnt_next    = '0;
                        groups_next = '0;
                        ovf_next    = 1'b0;
                        state_next  = S_LOAD;
                    end else begin
                        j_next     = j_reg + IW'(1);
                        state_next = S_E1_R1;
                    end
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            cnt_reg     <= '0;
            groups_reg  <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            groups_reg  <= groups_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
        j_reg <= j_next;
        k_reg <= k_next;
    end

endmodule

// ===== bench/usgc_checker.sv =====
module usgc_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_key_value,
    input  logic        s_last_item,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_kind,
    input  logic [31:0] m_distinct_key,
    input  logic [4:0]  m_first_position,
    input  logic [5:0]  m_occurrences,
    input  logic [4:0]  m_group_index,
    input  logic        m_overflow,
    input  logic        m_last_result,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_data,
    output int          failures,
    output int          pending,
    output int          words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = 32;

    typedef struct packed {
        logic        kind;
        logic [31:0] key;
        logic [4:0]  first;
        logic [5:0]  occ;
        logic [4:0]  grp;
        logic        ovf;
        logic        last;
    } word_t;

    word_t                    expected_words[$];
    logic                     ascending;
    logic signed [31:0]       set_keys[CAP];
    int                       set_len;
    logic                     set_dropped;
    int                       fail_cnt;
    int                       seen_cnt;

    task automatic group_set();
        int    firsts[$];
        int    tmp;
        int    cnt;
        bit    is_first;
        word_t w;
        for (int j = 0; j < set_len; j++) begin
            is_first = 1;
            for (int k = 0; k < j; k++)
                if (set_keys[k] == set_keys[j]) is_first = 0;
            if (is_first) firsts.insert(firsts.size(), j);
        end
        if (ascending) begin
            for (int a = 1; a < firsts.size(); a++)
                for (int b = a; b > 0 && set_keys[firsts[b]] < set_keys[firsts[b-1]]; b--) begin
                    tmp = firsts[b];
                    firsts[b] = firsts[b-1];
                    firsts[b-1] = tmp;
                end
        end
        foreach (firsts[g]) begin
            cnt = 0;
            for (int k = 0; k < set_len; k++)
                if (set_keys[k] == set_keys[firsts[g]]) cnt++;
            w = '0;
            w.kind  = usgc_pkg::KIND_DISTINCT;
            w.key   = set_keys[firsts[g]];
            w.first = firsts[g][4:0];
            w.occ   = cnt[5:0];
            w.ovf   = set_dropped;
            expected_words.insert(expected_words.size(), w);
        end
        for (int j = 0; j < set_len; j++) begin
            w = '0;
            w.kind = usgc_pkg::KIND_INVERSE;
            w.ovf  = set_dropped;
            foreach (firsts[g])
                if (set_keys[firsts[g]] == set_keys[j]) w.grp = g[4:0];
            if (j == set_len - 1) w.last = 1'b1;
            expected_words.insert(expected_words.size(), w);
        end
        set_len = 0;
        set_dropped = 0;
    endtask

    task automatic compare_word();
        word_t e;
        if (expected_words.size() == 0) begin
            $error("unexpected result word kind=%0d key=%0h", m_kind, m_distinct_key);
            fail_cnt++;
            return;
        end
        e = expected_words.pop_front();
        seen_cnt++;
        if (m_kind !== e.kind) begin
            $error("kind: expected %0d, got %0d", e.kind, m_kind); fail_cnt++;
        end
        if (m_distinct_key !== e.key) begin
            $error("distinct_key: expected %0h, got %0h", e.key, m_distinct_key); fail_cnt++;
        end
        if (m_first_position !== e.first) begin
            $error("first_position: expected %0d, got %0d", e.first, m_first_position);
            fail_cnt++;
        end
        if (m_occurrences !== e.occ) begin
            $error("occurrences: expected %0d, got %0d", e.occ, m_occurrences); fail_cnt++;
        end
        if (m_group_index !== e.grp) begin
            $error("group_index: expected %0d, got %0d", e.grp, m_group_index); fail_cnt++;
        end
        if (m_overflow !== e.ovf) begin
            $error("overflow: expected %0d, got %0d", e.ovf, m_overflow); fail_cnt++;
        end
        if (m_last_result !== e.last) begin
            $error("last_result: expected %0d, got %0d", e.last, m_last_result); fail_cnt++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            ascending = 1'b1;
            set_len = 0;
            set_dropped = 0;
            expected_words.delete();
            fail_cnt = 0;
            seen_cnt = 0;
        end else begin
            if (cfg_valid && cfg_ready) ascending = cfg_data;
            if (m_valid && m_ready) compare_word();
            if (s_valid && s_ready) begin
                if (set_len < CAP) begin
                    set_keys[set_len] = s_key_value;
                    set_len++;
                end else begin
                    set_dropped = 1;
                end
                if (s_last_item) group_set();
            end
        end
        failures      <= fail_cnt;
        pending       <= expected_words.size();
        words_checked <= seen_cnt;
    end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic ORDER_FIRST_SEEN = 1'b0;
    localparam logic ORDER_ASCENDING  = 1'b1;
    localparam int   ITEM_TARGET      = 170;
    localparam int   FINAL_SET_LEN    = 34;
    localparam int   CYCLE_LIMIT      = 1000000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [31:0] s_key_value = '0;
    logic        s_last_item = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic        m_kind;
    logic [31:0] m_distinct_key;
    logic [4:0]  m_first_position;
    logic [5:0]  m_occurrences;
    logic [4:0]  m_group_index;
    logic        m_overflow;
    logic        m_last_result;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic        cfg_data = 0;

    int failures, pending, words_checked;
    int cycles = 0;
    int burst_left = 0;
    int items_sent = 0;
    int sets_sent = 0;
    int overflow_sets = 0;
    logic [31:0] recent_keys[$];

    always #10 aclk = ~aclk;

    unique_sort_group_count dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_key_value, .s_last_item,
        .m_valid, .m_ready, .m_kind, .m_distinct_key, .m_first_position,
        .m_occurrences, .m_group_index, .m_overflow, .m_last_result,
        .cfg_valid, .cfg_ready, .cfg_data
    );

    usgc_checker chk (
        .aclk, .aresetn, .s_valid, .s_ready, .s_key_value, .s_last_item,
        .m_valid, .m_ready, .m_kind, .m_distinct_key, .m_first_position,
        .m_occurrences, .m_group_index, .m_overflow, .m_last_result,
        .cfg_valid, .cfg_ready, .cfg_data, .failures, .pending, .words_checked
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // sink: random stalls, ready-only stretches, one long hold-off
    initial begin
        int mode_left;
        int mode;
        bit held;
        mode_left = 0;
        mode = 0;
        held = 0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (!held && m_valid && cycles > 1000) begin
                held = 1;
                m_ready <= 1'b0;
                repeat (600) @(posedge aclk);
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(5, 60);
            end
            mode_left--;
            case (mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic send_word(input logic [31:0] key, input logic last);
        if (burst_left == 0) begin
            if (s_valid) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        s_valid     <= 1'b1;
        s_key_value <= key;
        s_last_item <= last;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (recent_keys.size() > 8) void'(recent_keys.pop_front());
        recent_keys.insert(recent_keys.size(), key);
    endtask

    task automatic drain();
        if (s_valid) s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_order(input logic order);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= order;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 16) - 8;
            1: case ($urandom_range(0, 3))
                   0: return 32'h8000_0000;
                   1: return 32'h7fff_ffff;
                   2: return 32'hffff_ffff;
                   default: return 32'h0;
               endcase
            2, 3: return $urandom();
            default: return recent_keys.size() ? recent_keys[$urandom_range(0,
                                recent_keys.size() - 1)] : $urandom();
        endcase
    endfunction

    task automatic send_set(input int len);
        for (int i = 0; i < len; i++)
            send_word(pick_key(), i == len - 1);
        sets_sent++;
        if (len > 32) overflow_sets++;
    endtask

    initial begin
        int len;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: single extreme key, duplicates around the sign boundary
        send_word(32'h8000_0000, 1'b1);
        sets_sent++;
        send_word(32'h7fff_ffff, 1'b0);
        send_word(32'hffff_ffff, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h7fff_ffff, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h0000_0001, 1'b1);
        sets_sent++;
        write_order(ORDER_FIRST_SEEN);
        send_word(32'd5, 1'b0);
        send_word(32'hffff_fffd, 1'b0);
        send_word(32'd5, 1'b0);
        send_word(32'hffff_fffd, 1'b0);
        send_word(32'd9, 1'b1);
        sets_sent++;
        write_order(ORDER_ASCENDING);
        for (int i = 0; i < 4; i++) send_word(32'h5a5a_a5a5, i == 3);
        sets_sent++;

        while (items_sent < ITEM_TARGET - FINAL_SET_LEN) begin
            if ($urandom_range(0, 4) == 0)
                write_order(1'($urandom_range(0, 1)));
            else if ($urandom_range(0, 3) == 0)
                drain();
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 36)
                                              : $urandom_range(1, 10);
            send_set(len);
        end
        // full store plus drops, in first-seen order
        write_order(ORDER_FIRST_SEEN);
        send_set(FINAL_SET_LEN);
        drain();

        $display("sent %0d keys in %0d sets (%0d over capacity), both orders",
                 items_sent, sets_sent, overflow_sets);
        $display("%0d result words compared", words_checked);
        if (failures == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
